### src/mtag_pkg.sv
package mtag_pkg;

	localparam int CHAIN_BITS = 5;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int LENGTH_BITS = 16;
	localparam int STRIDE_BITS = 16;

	localparam logic [CFG_ADDR_BITS-1:0] CFG_MODE = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_CHAIN_LENGTH = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_STRIDE_STEP = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_CHAIN_COUNT = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_PAYLOAD_ACCESS = 3'd4;

	typedef enum logic [2:0] {
		MODE_SEQ_LOAD = 3'd0,
		MODE_SEQ_STORE = 3'd1,
		MODE_STRIDE = 3'd2,
		MODE_RAND_LOAD = 3'd3,
		MODE_RAND_STORE = 3'd4
	} mode_t;

	localparam mode_t RST_MODE = MODE_SEQ_LOAD;
	localparam logic [LENGTH_BITS-1:0] RST_CHAIN_LENGTH = 16'd509;
	localparam logic [STRIDE_BITS-1:0] RST_STRIDE_STEP = 16'd1;
	localparam logic [CHAIN_BITS-1:0] RST_CHAIN_COUNT = 5'd1;
	localparam logic RST_PAYLOAD_ACCESS = 1'b1;

	// Per-step attributes shared by every access of the burst.
	typedef struct packed {
		logic is_store;
		logic touches_payload;
		logic [CHAIN_BITS-1:0] chains;
	} ctl_t;

endpackage

### src/mtag_fifo.sv
module mtag_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### src/mtag_front.sv
module mtag_front #(
	parameter int CHAIN_LIMIT = 20,
	parameter int INDEX_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [mtag_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [mtag_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 restart,
	input  logic                                 q_full,
	output logic                                 q_push,
	output logic [INDEX_BITS-1:0]                q_index,
	output mtag_pkg::ctl_t                       q_ctl
);

	localparam int WB = (INDEX_BITS > mtag_pkg::LENGTH_BITS) ? INDEX_BITS
		: mtag_pkg::LENGTH_BITS;
	localparam int SW = WB + 1;
	localparam int RW = WB + 3;

	mtag_pkg::mode_t                        mode_q;
	logic [mtag_pkg::LENGTH_BITS-1:0]       chain_length_q;
	logic [mtag_pkg::STRIDE_BITS-1:0]       stride_step_q;
	logic [mtag_pkg::CHAIN_BITS-1:0]        chain_count_q;
	logic                                   payload_access_q;

	logic [INDEX_BITS-1:0] step_q;
	logic [INDEX_BITS-1:0] pos_q;

	logic                  accept;
	logic                  seq;
	logic                  stride;
	logic                  store_mode;
	logic [INDEX_BITS-1:0] step_eff;
	logic [INDEX_BITS-1:0] pos_eff;
	logic [SW-1:0]         step_inc;
	logic [INDEX_BITS-1:0] next_step;
	logic [SW-1:0]         stride_sum;
	logic [SW-1:0]         stride_wrap;
	logic [INDEX_BITS-1:0] stride_pos;
	logic [mtag_pkg::LENGTH_BITS-1:0] half;
	logic signed [RW-1:0]  p_s;
	logic signed [RW-1:0]  n_s;
	logic signed [RW-1:0]  odd_s;
	logic signed [RW-1:0]  up1;
	logic signed [RW-1:0]  up2;
	logic signed [RW-1:0]  up3;
	logic signed [RW-1:0]  dn1;
	logic signed [RW-1:0]  dn2;
	logic signed [RW-1:0]  dn3;
	logic signed [RW-1:0]  mid;
	logic signed [RW-1:0]  rand_sel;
	logic [INDEX_BITS-1:0] next_pos;
	logic [mtag_pkg::CHAIN_BITS-1:0] chains;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign q_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mtag_pkg::RST_MODE;
			chain_length_q <= mtag_pkg::RST_CHAIN_LENGTH;
			stride_step_q <= mtag_pkg::RST_STRIDE_STEP;
			chain_count_q <= mtag_pkg::RST_CHAIN_COUNT;
			payload_access_q <= mtag_pkg::RST_PAYLOAD_ACCESS;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				mtag_pkg::CFG_MODE: begin
					mode_q <= mtag_pkg::mode_t'(cfg_wdata[2:0]);
				end
				mtag_pkg::CFG_CHAIN_LENGTH: begin
					chain_length_q <= cfg_wdata[mtag_pkg::LENGTH_BITS-1:0];
				end
				mtag_pkg::CFG_STRIDE_STEP: begin
					stride_step_q <= cfg_wdata[mtag_pkg::STRIDE_BITS-1:0];
				end
				mtag_pkg::CFG_CHAIN_COUNT: begin
					chain_count_q <= cfg_wdata[mtag_pkg::CHAIN_BITS-1:0];
				end
				mtag_pkg::CFG_PAYLOAD_ACCESS: begin
					payload_access_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Undefined mode codes fall back to sequential load.
	always_comb begin
		seq = 1'b1;
		stride = 1'b0;
		store_mode = 1'b0;
		unique case (mode_q)
			mtag_pkg::MODE_SEQ_LOAD: begin
			end
			mtag_pkg::MODE_SEQ_STORE: begin
				store_mode = 1'b1;
			end
			mtag_pkg::MODE_STRIDE: begin
				seq = 1'b0;
				stride = 1'b1;
			end
			mtag_pkg::MODE_RAND_LOAD: begin
				seq = 1'b0;
			end
			mtag_pkg::MODE_RAND_STORE: begin
				seq = 1'b0;
				store_mode = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign step_eff = restart ? '0 : step_q;
	assign pos_eff = restart ? '0 : pos_q;

	assign step_inc = SW'(step_eff) + SW'(1);
	assign next_step = (step_inc >= SW'(chain_length_q)) ? '0 : step_inc[INDEX_BITS-1:0];

	assign stride_sum = SW'(pos_eff) + SW'(stride_step_q);
	assign stride_wrap = stride_sum - SW'(chain_length_q);
	assign stride_pos = (stride_sum >= SW'(chain_length_q)) ? stride_wrap[INDEX_BITS-1:0]
		: stride_sum[INDEX_BITS-1:0];

	// The walk computes every correction in parallel and picks the first in range.
	assign half = (chain_length_q == '0) ? '0 : ((chain_length_q - 1'b1) >> 1);
	assign p_s = RW'(pos_eff);
	assign n_s = RW'(chain_length_q);
	assign odd_s = RW'({step_eff, 1'b1});
	assign up1 = p_s + odd_s;
	assign up2 = up1 - n_s;
	assign up3 = up1 - (n_s <<< 1);
	assign dn1 = p_s - odd_s;
	assign dn2 = dn1 + n_s;
	assign dn3 = dn1 + (n_s <<< 1);
	assign mid = n_s - p_s;

	always_comb begin
		if (WB'(step_eff) < WB'(half)) begin
			if (up1 < n_s) begin
				rand_sel = up1;
			end else if (up2 < n_s) begin
				rand_sel = up2;
			end else begin
				rand_sel = up3;
			end
		end else if (WB'(step_eff) == WB'(half)) begin
			rand_sel = mid;
		end else begin
			if (!dn1[RW-1]) begin
				rand_sel = dn1;
			end else if (!dn2[RW-1]) begin
				rand_sel = dn2;
			end else begin
				rand_sel = dn3;
			end
		end
	end

	always_comb begin
		if (seq) begin
			next_pos = next_step;
		end else if (stride) begin
			next_pos = stride_pos;
		end else begin
			next_pos = rand_sel[INDEX_BITS-1:0];
		end
	end

	always_comb begin
		if (chain_count_q == '0) begin
			chains = mtag_pkg::CHAIN_BITS'(1);
		end else if (int'(chain_count_q) > CHAIN_LIMIT) begin
			chains = mtag_pkg::CHAIN_BITS'(CHAIN_LIMIT);
		end else begin
			chains = chain_count_q;
		end
	end

	assign q_index = seq ? step_eff : pos_eff;
	assign q_ctl.is_store = store_mode && payload_access_q;
	assign q_ctl.touches_payload = payload_access_q;
	assign q_ctl.chains = chains;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			step_q <= next_step;
			pos_q <= next_pos;
		end
	end

endmodule

### src/mtag_back.sv
module mtag_back #(
	parameter int INDEX_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  logic [INDEX_BITS-1:0]             q_index,
	input  mtag_pkg::ctl_t                    q_ctl,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mtag_pkg::CHAIN_BITS-1:0]   chain_sel,
	output logic [INDEX_BITS-1:0]             element_index,
	output logic                              is_store,
	output logic                              touches_payload,
	output logic                              last_of_step
);

	logic                            out_valid_q;
	logic [mtag_pkg::CHAIN_BITS-1:0] cnt_q;
	logic [mtag_pkg::CHAIN_BITS-1:0] chain_sel_q;
	logic [INDEX_BITS-1:0]           element_index_q;
	logic                            is_store_q;
	logic                            touches_payload_q;
	logic                            last_q;
	logic                            load;
	logic                            issue;
	logic                            is_last;

	assign load = !out_valid_q || !out_stall;
	assign issue = load && !q_empty;
	assign is_last = (cnt_q == (q_ctl.chains - 1'b1));
	assign q_pop = issue && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (issue) begin
				cnt_q <= is_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chain_sel_q <= cnt_q;
			element_index_q <= q_index;
			is_store_q <= q_ctl.is_store;
			touches_payload_q <= q_ctl.touches_payload;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign chain_sel = chain_sel_q;
	assign element_index = element_index_q;
	assign is_store = is_store_q;
	assign touches_payload = touches_payload_q;
	assign last_of_step = last_q;

endmodule

### src/memory_traffic_address_generator.sv
// An item is taken at most once per cycle while the two-entry step queue has room.
// Its accesses reach the output through the step queue and then the output register, which
// issues one access per cycle while out_stall is low; each item yields one access per chain.
// Reset is asynchronous and active low: registers take their defaults, step and index clear,
// and the queue and output register empty.
module memory_traffic_address_generator #(
	parameter int CHAIN_LIMIT = 20,
	parameter int INDEX_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mtag_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [mtag_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mtag_pkg::CHAIN_BITS-1:0]     chain_sel,
	output logic [INDEX_BITS-1:0]               element_index,
	output logic                                is_store,
	output logic                                touches_payload,
	output logic                                last_of_step
);

	localparam int QW = INDEX_BITS + $bits(mtag_pkg::ctl_t);

	logic                  q_full;
	logic                  q_empty;
	logic                  q_push;
	logic                  q_pop;
	logic [INDEX_BITS-1:0] push_index;
	mtag_pkg::ctl_t        push_ctl;
	logic [QW-1:0]         pop_data;
	logic [INDEX_BITS-1:0] pop_index;
	mtag_pkg::ctl_t        pop_ctl;

	mtag_front #(
		.CHAIN_LIMIT (CHAIN_LIMIT),
		.INDEX_BITS  (INDEX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_index   (push_index),
		.q_ctl     (push_ctl)
	);

	mtag_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_index, push_ctl}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	assign pop_index = pop_data[QW-1 -: INDEX_BITS];
	assign pop_ctl = mtag_pkg::ctl_t'(pop_data[$bits(mtag_pkg::ctl_t)-1:0]);

	mtag_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_index         (pop_index),
		.q_ctl           (pop_ctl),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chain_sel       (chain_sel),
		.element_index   (element_index),
		.is_store        (is_store),
		.touches_payload (touches_payload),
		.last_of_step    (last_of_step)
	);

endmodule
